[rtl/core/brs_pkg.sv]
package brs_pkg;

  // fixed widths of the result fields
  localparam int unsigned ScoreW = 7;
  localparam int unsigned CountW = 13;
  localparam int unsigned DistW  = 9;

  // scoring constants
  localparam int unsigned ScoreMax    = 100;
  localparam int unsigned BonusBase   = 30;
  localparam int unsigned BonusLimit  = 16;
  // extra numerator bits for the weight of 40 (and 30)
  localparam int unsigned WeightBits  = 6;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_LOAD_A,
    ST_DIV_A,
    ST_LOAD_B,
    ST_DIV_B,
    ST_SCORE,
    ST_RESULT
  } brs_state_e;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_sel_b;
    logic div_step;
    logic score_load;
    logic clear;
  } brs_cmd_t;

  typedef struct packed {
    logic div_last;
  } brs_status_t;

endpackage

[rtl/core/brs_ctrl.sv]
module brs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_byte_i,
  input  logic                 out_stall_i,
  input  brs_pkg::brs_status_t status_i,
  output brs_pkg::brs_cmd_t    cmd_o,
  output logic                 in_stall_o,
  output logic                 out_valid_o
);
  import brs_pkg::*;

  brs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_valid_i && last_byte_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_LOAD_A;
      ST_LOAD_A: state_d = ST_DIV_A;
      ST_DIV_A: begin
        if (status_i.div_last) begin
          state_d = ST_LOAD_B;
        end
      end
      ST_LOAD_B: state_d = ST_DIV_B;
      ST_DIV_B: begin
        if (status_i.div_last) begin
          state_d = ST_SCORE;
        end
      end
      ST_SCORE:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_stall_i) begin
          state_d = ST_COLLECT;
        end
      end
      default:   state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_DRAIN: begin
      end
      ST_LOAD_A: begin
        cmd_o.div_load = 1'b1;
      end
      ST_DIV_A: begin
        cmd_o.div_step = 1'b1;
      end
      ST_LOAD_B: begin
        cmd_o.div_load  = 1'b1;
        cmd_o.div_sel_b = 1'b1;
      end
      ST_DIV_B: begin
        cmd_o.div_step = 1'b1;
      end
      ST_SCORE: begin
        cmd_o.score_load = 1'b1;
      end
      ST_RESULT: begin
        out_valid_o = 1'b1;
        cmd_o.clear = !out_stall_i;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/brs_datapath.sv]
module brs_datapath #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brs_pkg::brs_cmd_t               cmd_i,
  output brs_pkg::brs_status_t            status_o,
  input  logic [7:0]                      data_byte_i,
  output logic [brs_pkg::ScoreW-1:0]      repetition_score_o,
  output logic [brs_pkg::CountW-1:0]      top_count_o,
  output logic [brs_pkg::CountW-1:0]      longest_run_o,
  output logic [brs_pkg::DistW-1:0]       distinct_values_o,
  output logic                            overflow_o
);
  import brs_pkg::*;

  localparam int unsigned CW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned NW   = CW + WeightBits;
  localparam int unsigned CntW = $clog2(NW);
  localparam logic [CW-1:0] BufMax = CW'(BUFFER_BYTES);

  // histogram storage, valid bits stand for "nonzero this buffer"
  logic [CW-1:0] hist_mem [256];
  logic [255:0]  hval_q;
  logic [CW-1:0] rd_q;

  // second stage of the histogram update
  logic          pend_q;
  logic [7:0]    addr_q;
  logic          fwd_q;
  logic [CW-1:0] wdat_q;
  logic [CW-1:0] old_cnt, new_cnt;

  // buffer statistics
  logic [CW-1:0]    total_q, run_q, best_q, top_q;
  logic [CW-1:0]    total_d, run_d, best_d;
  logic [7:0]       prev_q;
  logic             sat_q;
  logic [DistW-1:0] dist_q;

  // shared divider
  logic [NW-1:0]   num_q, q1_q;
  logic [CW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic [CW:0]     rem_sh;
  logic            ge;
  logic [NW-1:0]   top_x40, best_x30;

  logic [7:0]        bonus, sum;
  logic [ScoreW-1:0] score_q;

  // read-modify-write of one histogram entry
  always_comb begin
    if (fwd_q) begin
      old_cnt = wdat_q;
    end else if (hval_q[addr_q]) begin
      old_cnt = rd_q;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt < BufMax) ? old_cnt + 1'b1 : old_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= hist_mem[data_byte_i];
    end
    if (pend_q) begin
      hist_mem[addr_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= data_byte_i;
    end
    if (pend_q) begin
      wdat_q <= new_cnt;
    end
  end

  // run and length updates happen as the byte is taken
  always_comb begin
    total_d = (total_q < BufMax) ? total_q + 1'b1 : total_q;
    if (total_q == '0 || data_byte_i == prev_q) begin
      run_d = (run_q < BufMax) ? run_q + 1'b1 : run_q;
    end else begin
      run_d = CW'(1);
    end
    best_d = (run_d > best_q) ? run_d : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      fwd_q   <= 1'b0;
      hval_q  <= '0;
      total_q <= '0;
      run_q   <= '0;
      best_q  <= '0;
      prev_q  <= '0;
      sat_q   <= 1'b0;
      top_q   <= '0;
      dist_q  <= '0;
    end else if (cmd_i.clear) begin
      pend_q  <= 1'b0;
      fwd_q   <= 1'b0;
      hval_q  <= '0;
      total_q <= '0;
      run_q   <= '0;
      best_q  <= '0;
      prev_q  <= '0;
      sat_q   <= 1'b0;
      top_q   <= '0;
      dist_q  <= '0;
    end else begin
      pend_q <= cmd_i.accept;
      if (cmd_i.accept) begin
        // entry written this cycle is read stale, so forward it
        fwd_q   <= pend_q && (addr_q == data_byte_i);
        total_q <= total_d;
        run_q   <= run_d;
        best_q  <= best_d;
        prev_q  <= data_byte_i;
        if (total_q >= BufMax) begin
          sat_q <= 1'b1;
        end
      end
      if (pend_q) begin
        hval_q[addr_q] <= 1'b1;
        if (new_cnt > top_q) begin
          top_q <= new_cnt;
        end
        if (old_cnt == '0) begin
          dist_q <= dist_q + 1'b1;
        end
      end
    end
  end

  // restoring divider, one quotient bit a cycle, divisor is the length
  assign top_x40  = (NW'(top_q) << 5) + (NW'(top_q) << 3);
  assign best_x30 = (NW'(best_q) << 5) - (NW'(best_q) << 1);
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign ge       = rem_sh >= {1'b0, total_q};
  assign status_o.div_last = (cnt_q == CntW'(NW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q <= cmd_i.div_sel_b ? best_x30 : top_x40;
      rem_q <= '0;
      cnt_q <= '0;
      if (cmd_i.div_sel_b) begin
        q1_q <= num_q;
      end
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? CW'(rem_sh - {1'b0, total_q}) : rem_sh[CW-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // bonus for few distinct values, then clip
  always_comb begin
    if (dist_q < DistW'(BonusLimit)) begin
      bonus = 8'(BonusBase) - {3'b000, dist_q[3:0], 1'b0};
    end else begin
      bonus = '0;
    end
    sum = 8'(q1_q) + 8'(num_q) + bonus;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.score_load) begin
      score_q <= (sum > 8'(ScoreMax)) ? ScoreW'(ScoreMax) : sum[ScoreW-1:0];
    end
  end

  assign repetition_score_o = score_q;
  assign top_count_o        = CountW'(top_q);
  assign longest_run_o      = CountW'(best_q);
  assign distinct_values_o  = dist_q;
  assign overflow_o         = sat_q;

endmodule

[rtl/core/byte_repetition_scorer.sv]
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  data_byte_i, last_byte_i
// out      output     out_valid_o / out_stall_i repetition_score_o, top_count_o,
//                                              longest_run_o, distinct_values_o,
//                                              overflow_o
//
// bytes of a buffer are taken one per cycle, with no gap between them
// after the last byte the input stalls while the histogram pipe drains, the
// shared one-bit-a-cycle divider runs twice and the score is formed, then the
// result item is offered
// input stays stalled until the result item is taken, then all counts clear
// reset brings up an empty buffer and a clear histogram at once (valid bits)
module byte_repetition_scorer #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte stream
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  // result
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [brs_pkg::ScoreW-1:0] repetition_score_o,
  output logic [brs_pkg::CountW-1:0] top_count_o,
  output logic [brs_pkg::CountW-1:0] longest_run_o,
  output logic [brs_pkg::DistW-1:0]  distinct_values_o,
  output logic                       overflow_o
);
  import brs_pkg::*;

  // command and status between sequencer and datapath
  brs_cmd_t    cmd;
  brs_status_t status;

  // sequencer: collect, drain histogram pipe, two divisions, score, hand off
  brs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // histogram memory, run tracking, divider and score
  brs_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .data_byte_i        (data_byte_i),
    .repetition_score_o (repetition_score_o),
    .top_count_o        (top_count_o),
    .longest_run_o      (longest_run_o),
    .distinct_values_o  (distinct_values_o),
    .overflow_o         (overflow_o)
  );

endmodule
